[sv/pcm_minor_frame_layout_core_assert.svh]
// ---------------------------------------------------------------------------
// pcm minor frame layout assertion macros
// same-cycle implication and next-cycle property checks on clk, reset rst
// ---------------------------------------------------------------------------
`ifndef PCM_MINOR_FRAME_LAYOUT_CORE_ASSERT_SVH
`define PCM_MINOR_FRAME_LAYOUT_CORE_ASSERT_SVH

// same-cycle implication
`define PMFL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PMFL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pmfl_pkg.sv]
// ---------------------------------------------------------------------------
// pmfl_pkg
// types and constants shared by the pcm minor frame layout core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pmfl_pkg;

  localparam int DATA_W    = 20;
  localparam int WORDS_W   = 14;
  localparam int WM1_W     = 13;
  localparam int BITS_W    = 7;
  localparam int FSUM_W    = 20;
  localparam int FBYTES_W  = 17;
  localparam int SBYTES_W  = 4;
  localparam int COUNT_W   = 16;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [WORDS_W-1:0] WORDS_MAX = 14'd8192;
  localparam logic [BITS_W-1:0]  BITS_MAX  = 7'd64;
  localparam logic [WORDS_W-1:0] WORDS_RESET = 14'd1;
  localparam logic [BITS_W-1:0]  BITS_RESET  = 7'd16;

  localparam int TIMESTAMP_BYTES = 8;
  localparam int HDR16_BYTES     = 2;
  localparam int HDR32_BYTES     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORDS       = 2'd0,
    CFG_COMMON_BITS = 2'd1,
    CFG_SYNC_BITS   = 2'd2
  } cfg_index_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_THROUGHPUT   = 3'd1,
    ST_NO_IP_HDR    = 3'd2,
    ST_NO_MODE      = 3'd3,
    ST_NOT_MULTIPLE = 3'd4
  } status_t;

  typedef struct packed {
    status_t               status;
    logic                  a32;
    logic                  unpacked;
    logic [DATA_W-1:0]     data;
    logic [WM1_W-1:0]      words_m1;
    logic [BITS_W-1:0]     cwb;
    logic [BITS_W-1:0]     sbits;
    logic [FSUM_W-1:0]     prod;
    logic [BITS_W-1:0]     placed;
    logic [FSUM_W-1:0]     fsum;
    logic [FBYTES_W-1:0]   fbytes;
    logic [FBYTES_W-1:0]   divisor;
    logic [SBYTES_W-1:0]   sbytes;
  } item_t;

endpackage

`default_nettype wire

[sv/pmfl_div_pipe.sv]
// ---------------------------------------------------------------------------
// pmfl_div_pipe
// restoring divider, one quotient bit per stage, with side payload and
// per-stage valid and ready
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmfl_div_pipe import pmfl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  item_t               in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output item_t               out_item,
  output logic [DATA_W-1:0]   out_quot,
  output logic [FBYTES_W-1:0] out_rem
);

  logic                v    [DATA_W];
  item_t               itm  [DATA_W];
  logic [FBYTES_W-1:0] rem  [DATA_W];
  logic [DATA_W-1:0]   quot [DATA_W];
  logic [DATA_W-1:0]   dvd  [DATA_W];
  logic                rdy  [DATA_W+1];

  assign rdy[DATA_W] = out_ready;

  for (genvar k = 0; k < DATA_W; k++) begin : g_stage
    logic                src_v;
    item_t               src_item;
    logic [FBYTES_W-1:0] src_rem;
    logic [DATA_W-1:0]   src_quot;
    logic [DATA_W-1:0]   src_dvd;
    logic [FBYTES_W:0]   trial;
    logic [FBYTES_W:0]   diff;
    logic                take;

    if (k == 0) begin : g_first
      assign src_v    = in_valid;
      assign src_item = in_item;
      assign src_rem  = '0;
      assign src_quot = '0;
      assign src_dvd  = in_item.data;
    end else begin : g_next
      assign src_v    = v[k-1];
      assign src_item = itm[k-1];
      assign src_rem  = rem[k-1];
      assign src_quot = quot[k-1];
      assign src_dvd  = dvd[k-1];
    end

    assign rdy[k] = !v[k] || rdy[k+1];
    assign trial  = {src_rem, src_dvd[DATA_W-1]};
    assign diff   = trial - {1'b0, src_item.divisor};
    assign take   = trial >= {1'b0, src_item.divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_v) begin
        itm[k]  <= src_item;
        rem[k]  <= take ? diff[FBYTES_W-1:0] : trial[FBYTES_W-1:0];
        quot[k] <= {src_quot[DATA_W-2:0], take};
        dvd[k]  <= {src_dvd[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[DATA_W-1];
  assign out_item  = itm[DATA_W-1];
  assign out_quot  = quot[DATA_W-1];
  assign out_rem   = rem[DATA_W-1];

endmodule

`default_nettype wire

[sv/pcm_minor_frame_layout_core.sv]
// ---------------------------------------------------------------------------
// pcm_minor_frame_layout_core
// minor frame layout and frame count for one pcm packet header
// ---------------------------------------------------------------------------
// input channel: in_valid / in_ready with the header fields; output channel:
// out_valid / out_ready with status, frame_count, frame_bytes, sync_bytes.
// configuration: cfg_we, cfg_index, cfg_data write one register per edge;
// write only while no word is in flight.
// pipeline: five layout stages, then twenty divider stages at one quotient
// bit each, then one output register. throughput: one word per cycle,
// sustained while the receiver keeps out_ready high.
// every stage has its own valid bit and loads whenever it is empty or its
// successor moves, so a stalled receiver only holds the words that have
// piled up behind it; the input keeps accepting until the pipeline fills.
// reset empties the pipeline and loads the register defaults
// (words per minor frame 1, common word bits 16, sync bits 16).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pcm_minor_frame_layout_core_assert.svh"

module pcm_minor_frame_layout_core import pmfl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_W-1:0]     packet_data_bytes,
  input  logic                  throughput_mode,
  input  logic                  packed_mode,
  input  logic                  unpacked_mode,
  input  logic                  align_32,
  input  logic                  has_ip_header,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   status,
  output logic [COUNT_W-1:0]    frame_count,
  output logic [FBYTES_W-1:0]   frame_bytes,
  output logic [SBYTES_W-1:0]   sync_bytes
);

  logic [WORDS_W-1:0] words_cfg;
  logic [BITS_W-1:0]  cwb_cfg;
  logic [BITS_W-1:0]  sbits_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      words_cfg <= WORDS_RESET;
      cwb_cfg   <= BITS_RESET;
      sbits_cfg <= BITS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WORDS:       words_cfg <= cfg_data[WORDS_W-1:0];
        CFG_COMMON_BITS: cwb_cfg   <= cfg_data[BITS_W-1:0];
        CFG_SYNC_BITS:   sbits_cfg <= cfg_data[BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped register values
  logic [WORDS_W-1:0] words_cl;
  logic [BITS_W-1:0]  cwb_cl;
  logic [BITS_W-1:0]  sbits_cl;

  always_comb begin
    words_cl = (words_cfg == '0) ? WORDS_RESET :
               (words_cfg > WORDS_MAX) ? WORDS_MAX : words_cfg;
    cwb_cl   = (cwb_cfg == '0) ? BITS_W'(1) :
               (cwb_cfg > BITS_MAX) ? BITS_MAX : cwb_cfg;
    sbits_cl = (sbits_cfg == '0) ? BITS_W'(1) :
               (sbits_cfg > BITS_MAX) ? BITS_MAX : sbits_cfg;
  end

  // stage valids and readiness chain
  logic  v0, v1, v2, v3, v4, ov;
  logic  r0, r1, r2, r3, r4, rout;
  logic  div_in_ready, div_out_valid;
  item_t s0, s1, s2, s3, s4;
  item_t s0_next, s1_next, s2_next, s3_next, s4_next;
  item_t div_item;
  logic [DATA_W-1:0]   div_quot;
  logic [FBYTES_W-1:0] div_rem;

  assign rout     = !ov || out_ready;
  assign r4       = !v4 || div_in_ready;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign r0       = !v0 || r1;
  assign in_ready = r0;

  // stage 0: status class and clamped configuration
  always_comb begin
    s0_next          = '0;
    s0_next.a32      = align_32;
    s0_next.unpacked = unpacked_mode;
    s0_next.data     = packet_data_bytes;
    s0_next.words_m1 = WM1_W'(words_cl - WORDS_W'(1));
    s0_next.cwb      = cwb_cl;
    s0_next.sbits    = sbits_cl;
    priority if (throughput_mode) begin
      s0_next.status = ST_THROUGHPUT;
    end else if (!has_ip_header) begin
      s0_next.status = ST_NO_IP_HDR;
    end else if (!unpacked_mode && !packed_mode) begin
      s0_next.status = ST_NO_MODE;
    end else begin
      s0_next.status = ST_OK;
    end
  end

  // stage 1: word bits product and placed sync length
  always_comb begin
    logic [BITS_W-1:0] mult;
    s1_next = s0;
    mult    = s0.unpacked ? BITS_W'(16) : s0.cwb;
    s1_next.prod = FSUM_W'(s0.words_m1 * mult);
    if (!s0.unpacked) begin
      s1_next.placed = s0.sbits;
    end else if (s0.sbits < BITS_W'(17)) begin
      s1_next.placed = BITS_W'(16);
    end else if (s0.sbits < BITS_W'(33)) begin
      s1_next.placed = BITS_W'(32);
    end else if (s0.a32 || s0.sbits > BITS_W'(48)) begin
      s1_next.placed = BITS_W'(64);
    end else begin
      s1_next.placed = BITS_W'(48);
    end
  end

  // stage 2: raw frame bits and sync bytes
  always_comb begin
    s2_next        = s1;
    s2_next.fsum   = s1.prod + FSUM_W'(s1.placed);
    s2_next.sbytes = SBYTES_W'(s1.placed >> 3);
  end

  // stage 3: pad to alignment, frame bytes
  always_comb begin
    logic [FSUM_W-1:0] padded;
    s3_next = s2;
    if (s2.a32) begin
      padded = (s2.fsum + FSUM_W'(31)) & ~FSUM_W'(31);
    end else begin
      padded = (s2.fsum + FSUM_W'(15)) & ~FSUM_W'(15);
    end
    s3_next.fbytes = padded[FSUM_W-1:3];
  end

  // stage 4: per-frame packet stride
  always_comb begin
    s4_next = s3;
    s4_next.divisor = s3.fbytes + (s3.a32 ? FBYTES_W'(HDR32_BYTES + TIMESTAMP_BYTES)
                                          : FBYTES_W'(HDR16_BYTES + TIMESTAMP_BYTES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r0) v0 <= in_valid;
      if (r1) v1 <= v0;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r0 && in_valid) s0 <= s0_next;
    if (r1 && v0)       s1 <= s1_next;
    if (r2 && v1)       s2 <= s2_next;
    if (r3 && v2)       s3 <= s3_next;
    if (r4 && v3)       s4 <= s4_next;
  end

  pmfl_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_ready  (div_in_ready),
    .in_item   (s4),
    .out_valid (div_out_valid),
    .out_ready (rout),
    .out_item  (div_item),
    .out_quot  (div_quot),
    .out_rem   (div_rem)
  );

  // output register
  status_t             status_q;
  logic [COUNT_W-1:0]  count_q;
  logic [FBYTES_W-1:0] fbytes_q;
  logic [SBYTES_W-1:0] sbytes_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (rout) begin
      ov <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rout && div_out_valid) begin
      if (div_item.status != ST_OK) begin
        status_q <= div_item.status;
        count_q  <= '0;
        fbytes_q <= '0;
        sbytes_q <= '0;
      end else begin
        status_q <= (div_rem != '0) ? ST_NOT_MULTIPLE : ST_OK;
        count_q  <= (div_quot[DATA_W-1:COUNT_W] != '0) ? '1 : div_quot[COUNT_W-1:0];
        fbytes_q <= div_item.fbytes;
        sbytes_q <= div_item.sbytes;
      end
    end
  end

  assign out_valid   = ov;
  assign status      = status_q;
  assign frame_count = count_q;
  assign frame_bytes = fbytes_q;
  assign sync_bytes  = sbytes_q;

  `PMFL_ASSERT_IMP(a_early_zero, out_valid && (status == ST_THROUGHPUT || status == ST_NO_IP_HDR || status == ST_NO_MODE), frame_count == '0 && frame_bytes == '0 && sync_bytes == '0, "early status word carries nonzero fields")
  `PMFL_ASSERT_IMP(a_frame_even, out_valid && (status == ST_OK || status == ST_NOT_MULTIPLE), frame_bytes != '0 && !frame_bytes[0], "frame size not a nonzero even byte count")
  `PMFL_ASSERT_NXT(a_front_load, in_valid && in_ready, v0, "accepted word missing from first stage")

endmodule

`default_nettype wire

[bench/tb_pcm_minor_frame_layout_core.sv]
// ---------------------------------------------------------------------------
// tb_pcm_minor_frame_layout_core
// self-checking bench for the pcm minor frame layout and frame count core
// ---------------------------------------------------------------------------
// a queue-fed driver offers packet headers and a clocked monitor checks every
// result word against a layout predictor that tracks the register settings.
// a short directed set covers the status paths, mode priority, the sync
// placement steps and count saturation. random phases follow, each under its
// own register setting (out-of-range values and extremes among them), with
// random idling on both sides, one calm phase and one long receiver hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_pcm_minor_frame_layout_core;
  import pmfl_pkg::*;

  localparam int IDLE_PCT    = 13;
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AT     = 400;
  localparam int TAIL_CYCLES = 40;
  localparam int STUCK_LIMIT = 4000;
  localparam int PHASE_ITEMS = 85;
  localparam int NUM_PHASES  = 10;
  localparam int DATA_MAX    = (1 << DATA_W) - 1;

  typedef struct packed {
    logic [DATA_W-1:0] data_bytes;
    logic              thru;
    logic              pack;
    logic              unpack;
    logic              a32;
    logic              iph;
  } header_t;

  typedef struct packed {
    status_t               status;
    logic [COUNT_W-1:0]    count;
    logic [FBYTES_W-1:0]   fbytes;
    logic [SBYTES_W-1:0]   sbytes;
  } layout_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [DATA_W-1:0]     packet_data_bytes = '0;
  logic                  throughput_mode = 1'b0;
  logic                  packed_mode = 1'b0;
  logic                  unpacked_mode = 1'b0;
  logic                  align_32 = 1'b0;
  logic                  has_ip_header = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [COUNT_W-1:0]    frame_count;
  logic [FBYTES_W-1:0]   frame_bytes;
  logic [SBYTES_W-1:0]   sync_bytes;

  // register copies as last written
  logic [WORDS_W-1:0] words_reg = WORDS_RESET;
  logic [BITS_W-1:0]  cwb_reg   = BITS_RESET;
  logic [BITS_W-1:0]  sync_reg  = BITS_RESET;

  header_t pending_headers[$];
  layout_t expected_layouts[$];
  header_t next_hdr;
  header_t accepted_hdr;
  layout_t want;

  logic    calm = 1'b0;
  int      hdrs_accepted = 0;
  int      results_seen = 0;
  int      mismatches = 0;
  int      settings_used = 1;
  int      hold_left = 0;
  logic    held_once = 1'b0;
  int      stuck_cycles = 0;

  int unsigned cfg_plan [8][3] = '{
    '{0, 0, 0}, '{16383, 127, 127}, '{8192, 64, 64}, '{1, 1, 1},
    '{2, 12, 17}, '{5, 10, 32}, '{100, 24, 65}, '{7, 33, 48}
  };

  pcm_minor_frame_layout_core uut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .packet_data_bytes (packet_data_bytes),
    .throughput_mode   (throughput_mode),
    .packed_mode       (packed_mode),
    .unpacked_mode     (unpacked_mode),
    .align_32          (align_32),
    .has_ip_header     (has_ip_header),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .frame_count       (frame_count),
    .frame_bytes       (frame_bytes),
    .sync_bytes        (sync_bytes)
  );

  always #5 clk = ~clk;

  function automatic layout_t predict_layout(header_t h);
    int unsigned words, cwb, sbits, align, placed, fbits, divisor, q;
    layout_t r;
    r = '{status: ST_OK, count: '0, fbytes: '0, sbytes: '0};
    words = (words_reg == 0) ? 1 : ((words_reg > WORDS_MAX) ? WORDS_MAX : words_reg);
    cwb   = (cwb_reg == 0) ? 1 : ((cwb_reg > BITS_MAX) ? BITS_MAX : cwb_reg);
    sbits = (sync_reg == 0) ? 1 : ((sync_reg > BITS_MAX) ? BITS_MAX : sync_reg);
    align = h.a32 ? 32 : 16;
    if (h.thru) begin
      r.status = ST_THROUGHPUT;
    end else if (!h.iph) begin
      r.status = ST_NO_IP_HDR;
    end else if (!h.unpack && !h.pack) begin
      r.status = ST_NO_MODE;
    end else begin
      if (h.unpack) begin
        if (sbits < 17) placed = 16;
        else if (sbits < 33) placed = 32;
        else placed = ((sbits + align - 1) / align) * align;
        fbits = (words - 1) * 16 + placed;
        if (h.a32 && (fbits % 32) != 0) fbits += 16;
      end else begin
        placed = sbits;
        fbits = (((words - 1) * cwb + sbits + align - 1) / align) * align;
      end
      r.sbytes = SBYTES_W'(placed / 8);
      r.fbytes = FBYTES_W'(fbits / 8);
      divisor = fbits / 8 + (h.a32 ? HDR32_BYTES : HDR16_BYTES) + TIMESTAMP_BYTES;
      q = h.data_bytes / divisor;
      r.count = (q > 65535) ? 16'hFFFF : COUNT_W'(q);
      r.status = ((h.data_bytes % divisor) != 0) ? ST_NOT_MULTIPLE : ST_OK;
    end
    return r;
  endfunction

  function automatic header_t make_header(int unsigned data, bit thru, bit pack,
                                          bit unpack, bit a32, bit iph);
    header_t h;
    h.data_bytes = DATA_W'(data);
    h.thru = thru;
    h.pack = pack;
    h.unpack = unpack;
    h.a32 = a32;
    h.iph = iph;
    return h;
  endfunction

  task automatic configure(int unsigned words, int unsigned cwb, int unsigned sbits);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_WORDS;
    cfg_data <= CFG_DATA_W'(words);
    words_reg = WORDS_W'(words);
    @(posedge clk);
    cfg_index <= CFG_COMMON_BITS;
    cfg_data <= CFG_DATA_W'(cwb);
    cwb_reg = BITS_W'(cwb);
    @(posedge clk);
    cfg_index <= CFG_SYNC_BITS;
    cfg_data <= CFG_DATA_W'(sbits);
    sync_reg = BITS_W'(sbits);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic settle();
    while (pending_headers.size() != 0 || in_valid || expected_layouts.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed headers, sizes biased toward exact multiples
  task automatic fill_random(int n);
    header_t h, probe;
    layout_t probe_layout;
    int unsigned divisor, r, k;
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      h.thru = ($urandom_range(99) < 8);
      h.iph = ($urandom_range(99) >= 8);
      if ($urandom_range(99) < 6) begin
        h.unpack = 1'b0;
        h.pack = 1'b0;
      end else begin
        h.unpack = 1'($urandom_range(1));
        h.pack = h.unpack ? 1'($urandom_range(1)) : 1'b1;
      end
      h.a32 = 1'($urandom_range(1));
      probe = h;
      probe.thru = 1'b0;
      probe.iph = 1'b1;
      probe.pack = 1'b1;
      probe.data_bytes = '0;
      probe_layout = predict_layout(probe);
      divisor = probe_layout.fbytes + (h.a32 ? HDR32_BYTES : HDR16_BYTES)
                + TIMESTAMP_BYTES;
      r = $urandom_range(99);
      if (r < 45) begin
        k = $urandom_range(DATA_MAX / divisor);
        h.data_bytes = DATA_W'(k * divisor);
      end else if (r < 65) begin
        k = $urandom_range((DATA_MAX - divisor) / divisor);
        h.data_bytes = DATA_W'(k * divisor + $urandom_range(1, divisor - 1));
      end else if (r < 80) begin
        h.data_bytes = DATA_W'($urandom_range(DATA_MAX));
      end else begin
        h.data_bytes = DATA_W'($urandom_range(4 * divisor));
      end
      pending_headers.push_back(h);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accepted_hdr = '{packet_data_bytes, throughput_mode, packed_mode, unpacked_mode,
                         align_32, has_ip_header};
        expected_layouts.push_back(predict_layout(accepted_hdr));
        hdrs_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_headers.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          next_hdr = pending_headers.pop_front();
          packet_data_bytes <= next_hdr.data_bytes;
          throughput_mode <= next_hdr.thru;
          packed_mode <= next_hdr.pack;
          unpacked_mode <= next_hdr.unpack;
          align_32 <= next_hdr.a32;
          has_ip_header <= next_hdr.iph;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_layouts.size() == 0) begin
          $error("result word with nothing expected: status %0d count %0d", status,
                 frame_count);
          mismatches++;
        end else begin
          want = expected_layouts.pop_front();
          if (status !== want.status) begin
            $error("status expected %0d got %0d", want.status, status);
            mismatches++;
          end
          if (frame_count !== want.count) begin
            $error("frame_count expected %0d got %0d", want.count, frame_count);
            mismatches++;
          end
          if (frame_bytes !== want.fbytes) begin
            $error("frame_bytes expected %0d got %0d", want.fbytes, frame_bytes);
            mismatches++;
          end
          if (sync_bytes !== want.sbytes) begin
            $error("sync_bytes expected %0d got %0d", want.sbytes, sync_bytes);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held_once && results_seen >= HOLD_AT) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int unsigned words, cwb, sbits;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: unpacked 12 byte step at 16-bit, 16 at 32-bit
    @(negedge clk);
    pending_headers.push_back(make_header(0, 1, 1, 1, 1, 1));
    pending_headers.push_back(make_header(DATA_MAX, 1, 0, 0, 0, 0));
    pending_headers.push_back(make_header(24, 0, 1, 1, 0, 0));
    pending_headers.push_back(make_header(DATA_MAX, 0, 0, 0, 1, 0));
    pending_headers.push_back(make_header(12, 0, 0, 0, 0, 1));
    pending_headers.push_back(make_header(0, 0, 0, 0, 1, 1));
    pending_headers.push_back(make_header(0, 0, 0, 1, 0, 1));
    pending_headers.push_back(make_header(12, 0, 0, 1, 0, 1));
    pending_headers.push_back(make_header(13, 0, 0, 1, 0, 1));
    pending_headers.push_back(make_header(32, 0, 0, 1, 1, 1));
    pending_headers.push_back(make_header(33, 0, 0, 1, 1, 1));
    pending_headers.push_back(make_header(24, 0, 1, 0, 0, 1));
    pending_headers.push_back(make_header(48, 0, 1, 0, 1, 1));
    pending_headers.push_back(make_header(50, 0, 1, 1, 0, 1));
    pending_headers.push_back(make_header(DATA_MAX, 0, 0, 1, 0, 1));
    pending_headers.push_back(make_header(1048572, 0, 1, 0, 0, 1));
    pending_headers.push_back(make_header(DATA_MAX, 0, 1, 1, 1, 1));
    pending_headers.push_back(make_header(524288, 0, 0, 1, 1, 1));
    settle();

    // long sync word rounded to the alignment
    configure(3, 12, 33);
    @(negedge clk);
    pending_headers.push_back(make_header(40, 0, 0, 1, 0, 1));
    pending_headers.push_back(make_header(48, 0, 0, 1, 1, 1));
    pending_headers.push_back(make_header(36, 0, 1, 0, 0, 1));
    pending_headers.push_back(make_header(41, 0, 1, 0, 1, 1));
    pending_headers.push_back(make_header(40, 0, 0, 0, 0, 1));
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 8) begin
        words = cfg_plan[p][0];
        cwb = cfg_plan[p][1];
        sbits = cfg_plan[p][2];
      end else begin
        words = ($urandom_range(3) == 0) ? $urandom_range(16383) : $urandom_range(1, 40);
        cwb = $urandom_range(127);
        sbits = $urandom_range(127);
      end
      configure(words, cwb, sbits);
      calm = (p == 2);
      fill_random(PHASE_ITEMS);
      settle();
      calm = 1'b0;
    end

    $display("checked %0d result words from %0d packet headers over %0d register settings",
             results_seen, hdrs_accepted, settings_used);
    $display("status paths, sync placement, count saturation and a full-pipeline stall seen");
    if (mismatches == 0 && expected_layouts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
